// ===== rtl/core/pfc_pkg.sv =====
// Package for the PCM packet framer: sizes, byte slot codes, the command
// record passed from front to back, and the CRC-16/CCITT byte update.
// No dependencies.
package pfc_pkg;

	// Largest packet size in samples and the widths that follow from it.
	localparam int MAX_SAMPLES = 1024;
	localparam int SIZE_W      = $clog2(MAX_SAMPLES + 1);
	localparam int POS_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	// Fixed field widths.
	localparam int CFG_SIZE_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int SAMPLE_W   = 16;
	localparam int STAMP_W    = 32;
	localparam int SEQ_W      = 32;
	localparam int LEN_W      = 16;
	localparam int CRC_W      = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_PACKET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_ENABLE         = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [CFG_SIZE_W-1:0] SPP_RESET = 11'd1024;
	localparam logic                  CRC_EN_RESET = 1'b1;

	// Framing constants.
	localparam logic [7:0]       SYNC_BYTE = 8'hA6;
	localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;
	localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;

	// Command queue depth.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Byte slot codes within the bytes caused by one sample.
	localparam logic [3:0] IDX_SYNC    = 4'd0;
	localparam logic [3:0] IDX_LEN_LO  = 4'd1;
	localparam logic [3:0] IDX_LEN_HI  = 4'd2;
	localparam logic [3:0] IDX_SEQ_B0  = 4'd3;
	localparam logic [3:0] IDX_SEQ_B1  = 4'd4;
	localparam logic [3:0] IDX_SEQ_B2  = 4'd5;
	localparam logic [3:0] IDX_SEQ_B3  = 4'd6;
	localparam logic [3:0] IDX_TS_B0   = 4'd7;
	localparam logic [3:0] IDX_TS_B1   = 4'd8;
	localparam logic [3:0] IDX_TS_B2   = 4'd9;
	localparam logic [3:0] IDX_TS_B3   = 4'd10;
	localparam logic [3:0] IDX_SMP_LO  = 4'd11;
	localparam logic [3:0] IDX_SMP_HI  = 4'd12;
	localparam logic [3:0] IDX_CRC_LO  = 4'd13;
	localparam logic [3:0] IDX_CRC_HI  = 4'd14;

	// One classified sample, ready for serialisation.
	typedef struct packed {
		logic                       first;
		logic                       last;
		logic                       crc_en;
		logic [LEN_W-1:0]           len;
		logic [SEQ_W-1:0]           seq;
		logic [STAMP_W-1:0]         stamp;
		logic signed [SAMPLE_W-1:0] sample;
	} pfc_cmd_t;

	// CRC-16/CCITT update with one byte, most significant bit first.
	function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
			input logic [7:0] data);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/pfc_front.sv =====
// Front part of the framer: configuration registers, packet position and
// sequence counters, and classification of each accepted sample.
// Depends on pfc_pkg.
module pfc_front import pfc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_SIZE_W-1:0]      cfg_data,
	input  logic                       in_accept,
	input  logic signed [SAMPLE_W-1:0] pcm_sample,
	input  logic [STAMP_W-1:0]         timestamp_us,
	output pfc_cmd_t                   cmd
);

	logic [CFG_SIZE_W-1:0] spp_q;
	logic                  crc_en_q;
	logic [POS_W-1:0]      pos_q;
	logic [SEQ_W-1:0]      seq_q;
	logic [SIZE_W-1:0]     eff_size;
	logic [SIZE_W-1:0]     pos_next;
	logic                  first;
	logic                  last;

	// Configuration writes; unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q    <= SPP_RESET;
			crc_en_q <= CRC_EN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLES_PER_PACKET: spp_q <= cfg_data;
				REG_CRC_ENABLE:         crc_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective packet size: zero acts as one, large values are clamped.
	always_comb begin
		if (spp_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (spp_q > MAX_SAMPLES) begin
			eff_size = SIZE_W'(MAX_SAMPLES);
		end else begin
			eff_size = SIZE_W'(spp_q);
		end
	end

	// Classification of the sample being accepted.
	assign first    = (pos_q == '0);
	assign pos_next = SIZE_W'(pos_q) + SIZE_W'(1);
	assign last     = (pos_next >= eff_size);

	assign cmd.first  = first;
	assign cmd.last   = last;
	assign cmd.crc_en = crc_en_q;
	assign cmd.len    = LEN_W'({LEN_W'(eff_size), 1'b0});
	assign cmd.seq    = seq_q;
	assign cmd.stamp  = timestamp_us;
	assign cmd.sample = pcm_sample;

	// Position within the packet and the packet sequence number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			seq_q <= '0;
		end else if (in_accept) begin
			if (last) begin
				pos_q <= '0;
			end else begin
				pos_q <= POS_W'(pos_next);
			end
			if (first) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pfc_cmd_fifo.sv =====
// Short command queue between the front and back parts of the framer; depends on
// pfc_pkg. Register based, one push and one pop per cycle, unless full or empty.
module pfc_cmd_fifo import pfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  pfc_cmd_t push_data,
	input  logic     pop,
	output pfc_cmd_t head,
	output logic     empty,
	output logic     full
);

	pfc_cmd_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == (FIFO_AW + 1)'(FIFO_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (FIFO_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (FIFO_AW + 1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/pfc_back.sv =====
// Back part of the framer: serialises each queued command into header,
// payload and trailer bytes, runs the CRC and holds the output register.
// Depends on pfc_pkg.
module pfc_back import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pfc_cmd_t   head,
	input  logic       head_valid,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	logic              busy_q;
	logic [3:0]        idx_q;
	logic [CRC_W-1:0]  crc_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_pend_q;
	logic [3:0]        start_idx;
	logic [3:0]        end_idx;
	logic [3:0]        cur_idx;
	logic              advance;
	logic [7:0]        byte_sel;
	logic [CRC_W-1:0]  crc_base;
	logic [CRC_W-1:0]  crc_val;

	// Byte slot sequence for the command at the head of the queue.
	assign start_idx = head.first ? IDX_SYNC : IDX_SMP_LO;
	assign end_idx   = head.last ? IDX_CRC_HI : IDX_SMP_HI;
	assign cur_idx   = busy_q ? idx_q : start_idx;
	assign advance   = head_valid && (!out_valid_q || m_tready);
	assign pop       = advance && (cur_idx == end_idx);
	assign crc_val   = head.crc_en ? crc_q : '0;
	assign crc_base  = (cur_idx == IDX_SYNC) ? CRC_INIT : crc_q;

	// Byte selection for the current slot.
	always_comb begin
		case (cur_idx)
			IDX_SYNC:   byte_sel = SYNC_BYTE;
			IDX_LEN_LO: byte_sel = head.len[7:0];
			IDX_LEN_HI: byte_sel = head.len[15:8];
			IDX_SEQ_B0: byte_sel = head.seq[7:0];
			IDX_SEQ_B1: byte_sel = head.seq[15:8];
			IDX_SEQ_B2: byte_sel = head.seq[23:16];
			IDX_SEQ_B3: byte_sel = head.seq[31:24];
			IDX_TS_B0:  byte_sel = head.stamp[7:0];
			IDX_TS_B1:  byte_sel = head.stamp[15:8];
			IDX_TS_B2:  byte_sel = head.stamp[23:16];
			IDX_TS_B3:  byte_sel = head.stamp[31:24];
			IDX_SMP_LO: byte_sel = head.sample[7:0];
			IDX_SMP_HI: byte_sel = head.sample[15:8];
			IDX_CRC_LO: byte_sel = crc_val[7:0];
			IDX_CRC_HI: byte_sel = crc_val[15:8];
			default:    byte_sel = '0;
		endcase
	end

	// Slot counter and running CRC; trailer bytes are not accumulated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= IDX_SYNC;
			crc_q  <= CRC_INIT;
		end else if (advance) begin
			if (cur_idx == end_idx) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				idx_q  <= cur_idx + 4'd1;
			end
			if (cur_idx <= IDX_SMP_HI) begin
				crc_q <= crc_step(crc_base, byte_sel);
			end
		end
	end

	// Output register: a new byte is loaded when a command is queued and the register is empty or its byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_sel;
			out_last_q <= (cur_idx == end_idx);
			out_pend_q <= (cur_idx == IDX_CRC_HI);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_pend_q;

`ifndef NO_ASSERTIONS
	// The end of a packet is always the last byte of its sample.
	a_pend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("packet end without item end");

	// A command being serialised stays at the head of the queue.
	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> head_valid)
		else $error("queue emptied during a command");

	// After the first byte the slot counter never points at the sync slot or past the last CRC slot.
	a_busy_not_sync: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q != IDX_SYNC) && (idx_q <= IDX_CRC_HI))
		else $error("slot counter out of sequence");
`endif

endmodule

// ===== rtl/core/pcm_packet_framer_crc16.sv =====
// PCM packet framer with CRC-16/CCITT trailer: top level.
// Instantiates pfc_front, pfc_cmd_fifo and pfc_back; depends on pfc_pkg.
//
// Usage:
//  - Slave stream s_*: one transaction per PCM sample; s_tdata carries
//    pcm_sample in bits 15:0 and timestamp_us in bits 47:16.
//  - Master stream m_*: one transaction per output byte; m_tlast marks the
//    last byte caused by a sample, m_tuser the final CRC byte of a packet.
//  - Configuration channel cfg_*: register 0 is samples_per_packet, register
//    1 is crc_enable; always ready, and written only while the block is idle:
//    a rule for the user, which the block itself does not enforce.
//  - If idle, a sample's first byte reaches m_* via the queue and output register.
//  - The serialiser gives one byte per cycle while a command is queued and the
//    receiver is ready: 2 per sample, plus 11 header bytes on the first and 2
//    trailer bytes on the last, so 2*N + 13 bytes per packet of N samples.
//  - The four-entry command queue keeps accepting samples while the receiver
//    stalls; once it is full, s_tready drops until bytes are taken again.
//  - Reset clears the sequence number, packet position and CRC, and returns
//    the registers to 1024 samples per packet with the CRC enabled.
module pcm_packet_framer_crc16 import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // [15:0] pcm_sample, [47:16] timestamp_us
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [7:0] out_byte
	output logic                  m_tlast,
	output logic                  m_tuser,   // [0] packet_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_SIZE_W-1:0] cfg_data
);

	pfc_cmd_t cmd;
	pfc_cmd_t head;
	logic     fifo_empty;
	logic     fifo_full;
	logic     pop;
	logic     in_accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !fifo_full;
	assign in_accept = s_tvalid && !fifo_full;

	// Front: configuration, counters and sample classification.
	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_accept    (in_accept),
		.pcm_sample   (s_tdata[15:0]),
		.timestamp_us (s_tdata[47:16]),
		.cmd          (cmd)
	);

	// Command queue between front and back.
	pfc_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	// Back: byte serialiser, CRC and output register.
	pfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!fifo_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== bench/pfc_checker.sv =====
// Scoreboard for the PCM packet framer: watches the sample, byte and register
// channels, forms the expected byte stream and compares every byte with it.
// Depends on pfc_pkg.
module pfc_checker import pfc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [47:0]           s_tdata,   // [15:0] pcm_sample, [47:16] timestamp_us
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [7:0]            m_tdata,   // [7:0] out_byte
	input  logic                  m_tlast,
	input  logic                  m_tuser,   // [0] packet_end
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_SIZE_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding,
	output int                    packets_closed,
	output int                    bytes_checked
);

	// One expected byte of the framed stream with its two markers.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pkt_end;
	} frame_byte_t;

	frame_byte_t           byte_q[$];
	logic [CFG_SIZE_W-1:0] size_reg = SPP_RESET;
	logic                  crc_on = CRC_EN_RESET;
	logic [SEQ_W-1:0]      seq_no = '0;
	int unsigned           fill = 0;
	logic [CRC_W-1:0]      crc_acc = CRC_INIT;

	initial begin
		mismatches = 0;
		outstanding = 0;
		packets_closed = 0;
		bytes_checked = 0;
	end

	// CRC-16/CCITT, one data bit at a time against the top bit of the register.
	function automatic logic [CRC_W-1:0] ccitt_fold(input logic [CRC_W-1:0] acc,
			input logic [7:0] b);
		logic [CRC_W-1:0] r;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			if (r[CRC_W-1] ^ b[k]) begin
				r = (r << 1) ^ CRC_POLY;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	// Queue one byte, folding it into the packet CRC where it is covered.
	function void emit(input logic [7:0] b, input logic covered, input logic last,
			input logic pkt_end);
		frame_byte_t fb;
		fb.data = b;
		fb.last = last;
		fb.pkt_end = pkt_end;
		byte_q.push_back(fb);
		if (covered) begin
			crc_acc = ccitt_fold(crc_acc, b);
		end
	endfunction

	// Expected bytes for one accepted sample: header, payload and trailer.
	function void frame_sample(input logic [SAMPLE_W-1:0] smp, input logic [STAMP_W-1:0] stamp);
		int unsigned      n;
		logic [LEN_W-1:0] len;
		logic [CRC_W-1:0] trailer;
		logic             closes;
		n = size_reg;
		if (n == 0) begin
			n = 1;
		end
		if (n > MAX_SAMPLES) begin
			n = MAX_SAMPLES;
		end
		if (fill == 0) begin
			len = 16'(n * 2);
			crc_acc = CRC_INIT;
			emit(SYNC_BYTE, 1'b1, 1'b0, 1'b0);
			emit(len[7:0], 1'b1, 1'b0, 1'b0);
			emit(len[15:8], 1'b1, 1'b0, 1'b0);
			for (int k = 0; k < 4; k++) begin
				emit(seq_no[8*k +: 8], 1'b1, 1'b0, 1'b0);
			end
			for (int k = 0; k < 4; k++) begin
				emit(stamp[8*k +: 8], 1'b1, 1'b0, 1'b0);
			end
			seq_no = seq_no + 1'b1;
		end
		fill++;
		closes = (fill >= n);
		emit(smp[7:0], 1'b1, 1'b0, 1'b0);
		emit(smp[15:8], 1'b1, !closes, 1'b0);
		if (closes) begin
			trailer = crc_on ? crc_acc : '0;
			emit(trailer[7:0], 1'b0, 1'b0, 1'b0);
			emit(trailer[15:8], 1'b0, 1'b1, 1'b1);
			fill = 0;
			crc_acc = CRC_INIT;
		end
	endfunction

	// Print one line per mismatch and count it.
	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("pfc_checker: %s: got %0h, expected %0h, at byte %0d",
			what, got, want, bytes_checked);
		mismatches++;
	endtask

	// Register writes first, then sample transactions, then byte transactions.
	always @(posedge clk or negedge arst_n) begin : watch
		frame_byte_t want;
		if (!arst_n) begin
			size_reg = SPP_RESET;
			crc_on = CRC_EN_RESET;
			seq_no = '0;
			fill = 0;
			crc_acc = CRC_INIT;
			byte_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLES_PER_PACKET: begin
						size_reg = cfg_data;
					end
					REG_CRC_ENABLE: begin
						crc_on = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				frame_sample(s_tdata[15:0], s_tdata[47:16]);
			end
			if (m_tvalid && m_tready) begin
				if (byte_q.size() == 0) begin
					report("byte with nothing expected", m_tdata, 8'h00);
				end else begin
					want = byte_q.pop_front();
					if (m_tdata !== want.data) begin
						report("out_byte", m_tdata, want.data);
					end
					if (m_tlast !== want.last) begin
						report("item_end", {7'd0, m_tlast}, {7'd0, want.last});
					end
					if (m_tuser !== want.pkt_end) begin
						report("packet_end", {7'd0, m_tuser}, {7'd0, want.pkt_end});
					end
					if (want.pkt_end) begin
						packets_closed++;
					end
				end
				bytes_checked++;
			end
			outstanding <= byte_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// Testbench top for pcm_packet_framer_crc16: clock, reset, sample and register
// stimulus, receiver pacing, a stall watchdog and the verdict.
// Depends on pfc_pkg, pcm_packet_framer_crc16 and pfc_checker.
module tb;
	import pfc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_SLACK = 6;
	localparam int SAMPLE_TARGET = 460;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;   // [15:0] pcm_sample, [47:16] timestamp_us
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;        // [7:0] out_byte
	logic                  m_tlast;
	logic                  m_tuser;        // [0] packet_end
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_SIZE_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int packets_closed;
	int bytes_checked;
	int sent = 0;
	int settings_used = 0;
	int quiet = 0;
	int rx_hold = 0;
	int rx_calm = 0;
	bit burst = 1'b0;

	pcm_packet_framer_crc16 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pfc_checker i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.packets_closed(packets_closed),
		.bytes_checked (bytes_checked)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Receiver pacing: a random stall after each byte, with calm stretches.
	always @(posedge clk or negedge arst_n) begin : rx_pace
		int pause;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
			rx_calm <= 0;
		end else if (m_tvalid && m_tready) begin
			if (rx_calm > 0) begin
				pause = 0;
				rx_calm <= rx_calm - 1;
			end else begin
				pause = $urandom_range(0, 3);
				if ($urandom_range(0, 39) == 0) begin
					rx_calm <= $urandom_range(10, 60);
				end
			end
			rx_hold <= pause;
			m_tready <= (pause == 0);
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
		end else begin
			rx_hold <= 0;
			m_tready <= 1'b1;
		end
	end

	// Watchdog: ends the run when no transaction of any kind happens for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= STALL_LIMIT) begin
			$display("tb: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// Offer one sample after a drawn gap and hold it until it is taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic [STAMP_W-1:0] stamp);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {stamp, smp};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Present one register write; the caller lowers cfg_valid after the last one.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_SIZE_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Stop offering samples and wait until every expected byte has arrived.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Random sample with the extremes drawn more often than chance would.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7FFF;
			end
			2: begin
				return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Packet size: mostly small, sometimes zero, the maximum or beyond it.
	function automatic logic [CFG_SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 11'($urandom_range(1, 6));
		end else if (r < 75) begin
			return 11'($urandom_range(7, 24));
		end else if (r < 83) begin
			return '0;
		end else if (r < 90) begin
			return 11'($urandom_range(1025, 2047));
		end else if (r < 95) begin
			return 11'(MAX_SAMPLES);
		end
		return 11'($urandom_range(25, 64));
	endfunction

	initial begin
		int count;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two-sample packets with the field extremes.
		write_reg(REG_SAMPLES_PER_PACKET, 11'd2);
		write_reg(REG_CRC_ENABLE, 11'd1);
		cfg_valid <= 1'b0;
		settings_used++;
		send_sample(16'h0000, 32'h0000_0000);
		send_sample(16'h7FFF, 32'hFFFF_FFFF);
		send_sample(16'h8000, 32'h5555_5555);
		send_sample(16'hFFFF, 32'hAAAA_AAAA);
		drain();

		// One sample per packet, then a size of zero, which acts as one.
		write_reg(REG_SAMPLES_PER_PACKET, 11'd1);
		cfg_valid <= 1'b0;
		settings_used++;
		send_sample(16'h5555, 32'h1234_5678);
		send_sample(16'hAAAA, 32'h8000_0001);
		drain();
		write_reg(REG_SAMPLES_PER_PACKET, 11'd0);
		cfg_valid <= 1'b0;
		settings_used++;
		send_sample(pick_sample(), $urandom);
		send_sample(pick_sample(), $urandom);
		drain();

		// Zero trailer, then writes to undecoded indexes, which must change nothing.
		write_reg(REG_CRC_ENABLE, 11'd0);
		write_reg(REG_SAMPLES_PER_PACKET, 11'd3);
		cfg_valid <= 1'b0;
		settings_used++;
		repeat (3) send_sample(pick_sample(), $urandom);
		drain();
		write_reg(REG_SPARE_2, 11'($urandom));
		write_reg(REG_SPARE_3, 11'($urandom));
		cfg_valid <= 1'b0;
		repeat (3) send_sample(pick_sample(), $urandom);
		drain();

		// CRC switched on halfway through a packet: only the trailer sees it.
		write_reg(REG_SAMPLES_PER_PACKET, 11'd4);
		cfg_valid <= 1'b0;
		settings_used++;
		repeat (2) send_sample(pick_sample(), $urandom);
		drain();
		write_reg(REG_CRC_ENABLE, 11'd1);
		cfg_valid <= 1'b0;
		settings_used++;
		repeat (2) send_sample(pick_sample(), $urandom);
		drain();

		// Oversized setting acts as the maximum; a smaller size then cuts the packet.
		write_reg(REG_SAMPLES_PER_PACKET, 11'd2047);
		cfg_valid <= 1'b0;
		settings_used++;
		repeat (3) send_sample(pick_sample(), $urandom);
		drain();
		write_reg(REG_SAMPLES_PER_PACKET, 11'(MAX_SAMPLES));
		cfg_valid <= 1'b0;
		settings_used++;
		send_sample(pick_sample(), $urandom);
		drain();
		write_reg(REG_SAMPLES_PER_PACKET, 11'd2);
		cfg_valid <= 1'b0;
		settings_used++;
		send_sample(pick_sample(), $urandom);
		drain();

		// Random phases: new settings while idle, then a run of random samples.
		while (sent < SAMPLE_TARGET) begin
			if ($urandom_range(0, 4) != 0) begin
				write_reg(REG_SAMPLES_PER_PACKET, pick_size());
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_CRC_ENABLE, 11'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 9) == 0) begin
				write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3,
					11'($urandom));
			end
			cfg_valid <= 1'b0;
			settings_used++;
			burst = ($urandom_range(0, 4) == 0);
			count = $urandom_range(1, 24);
			repeat (count) send_sample(pick_sample(), $urandom);
			drain();
		end

		$display("tb: %0d samples over %0d settings, %0d packets closed, %0d bytes checked",
			sent, settings_used, packets_closed, bytes_checked);
		$display("tb: sizes of zero, one, the maximum and beyond, mid-packet changes included");
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
